>>> design/bfs_pkg.sv
package bfs_pkg;
    localparam int HOSTS_DEF       = 64;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_COUNT_DEF   = 256;

    localparam logic [1:0] OP_SUBMIT   = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_DECIDE   = 2'd2;

    localparam logic [1:0] RK_EXEC   = 2'd0;
    localparam logic [1:0] RK_REJECT = 2'd1;
    localparam logic [1:0] RK_DROP   = 2'd2;
    localparam logic [1:0] RK_END    = 2'd3;

    // queue cell control: hold, load at tail, shift left from index
    typedef struct packed {
        logic       load;
        logic       shift;
        logic [5:0] rm_idx;
        logic [5:0] tail;
    } t_qctl;
endpackage

>>> design/bfs_if.sv
interface bfs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] job_tag;
    logic [7:0] hosts_wanted;
    modport source (output valid, opcode, job_tag, hosts_wanted, input ready);
    modport sink   (input valid, opcode, job_tag, hosts_wanted, output ready);
endinterface

interface bfs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  result_tag;
    logic [63:0] host_mask;
    logic        last_of_batch;
    modport source (output valid, result_kind, result_tag, host_mask, last_of_batch,
                    input ready);
    modport sink   (input valid, result_kind, result_tag, host_mask, last_of_batch,
                    output ready);
endinterface

>>> design/bfs_ram.sv
module bfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/bfs_cell.sv
// One queue slot: holds a tag and size, loads at the tail, takes its right
// neighbour's entry when a slot at or below it is removed.
module bfs_cell import bfs_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  t_qctl      i_ctl,
    input  logic [7:0] i_tag,
    input  logic [7:0] i_size,
    input  logic [7:0] i_nb_tag,
    input  logic [7:0] i_nb_size,
    output logic [7:0] o_tag,
    output logic [7:0] o_size
);
    logic [7:0] r_tag, r_size;
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_ctl.tail == 6'(IDX)) begin
            r_tag  <= i_tag;
            r_size <= i_size;
        end else if (i_ctl.shift && 6'(IDX) >= i_ctl.rm_idx) begin
            r_tag  <= i_nb_tag;
            r_size <= i_nb_size;
        end
    end
    assign o_tag  = r_tag;
    assign o_size = r_size;
endmodule

>>> design/backfill_job_host_scheduler_unit.sv
// Channel | Dir | Payload
// in      | in  | opcode, job_tag, hosts_wanted
// out     | out | result_kind, result_tag, host_mask, last_of_batch
// cfg     | in  | i_cfg_we, i_cfg_data (host_count)
// Submit: in takes the next beat once any result beat it gives has left. Completion
// reads the running-mask RAM (states S_CRD, S_CWAIT). Decide tests queue slots in
// turn; each started job picks hosts lowest bit first, one host per cycle, then
// emits its beat. A batch-end beat follows. Queue is a row of cells shifted one
// slot per removal. Output beat is held in a register; emit and batch end wait
// while it is stalled. Reset synchronous, active low; RAM contents undefined, a
// valid bit per tag covers them.
module backfill_job_host_scheduler_unit import bfs_pkg::*; #(
    parameter int HOSTS       = HOSTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_COUNT   = TAG_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [6:0] i_cfg_data,
    bfs_in_if.sink    i_in,
    bfs_out_if.source o_out
);
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
    localparam int HW = $clog2(HOSTS + 1);
    localparam int PW = (HOSTS > 1) ? $clog2(HOSTS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_CRD, S_CWAIT, S_SCAN, S_PICK, S_EMIT, S_END}
        t_state;

    t_state            r_state;
    logic [HOSTS-1:0]  r_free, r_mask, r_work;
    logic [HW-1:0]     r_hc, r_avail, r_need;
    logic [QW-1:0]     r_cnt, r_idx;
    logic [TW-1:0]     r_ctag;
    logic              r_front_fail;
    logic [TAG_COUNT-1:0] r_rv;
    logic [HW-1:0]     r_pos;
    // output register
    logic        r_ov, r_olast;
    logic [1:0]  r_okind;
    logic [7:0]  r_otag;
    logic [63:0] r_omask;

    logic [7:0] w_tag [QUEUE_DEPTH+1];
    logic [7:0] w_size [QUEUE_DEPTH+1];
    t_qctl      w_ctl;
    logic       w_load, w_shift;

    assign w_tag[QUEUE_DEPTH]  = '0;
    assign w_size[QUEUE_DEPTH] = '0;
    assign w_ctl.load   = w_load;
    assign w_ctl.shift  = w_shift;
    assign w_ctl.rm_idx = 6'(r_idx);
    assign w_ctl.tail   = 6'(r_cnt);

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_q
        bfs_cell #(.IDX(g)) u_cell (
            .i_clk, .i_ctl(w_ctl),
            .i_tag(i_in.job_tag), .i_size(i_in.hosts_wanted),
            .i_nb_tag(w_tag[g+1]), .i_nb_size(w_size[g+1]),
            .o_tag(w_tag[g]), .o_size(w_size[g])
        );
    end

    logic       w_acc, w_oacc;
    logic [7:0] w_cur_tag, w_cur_size;
    logic [HW-1:0] w_cfg;
    logic [HOSTS-1:0] w_cfg_mask;
    logic       w_reject, w_full, w_end_go, w_oset;

    logic [HOSTS-1:0] w_rdata;
    logic             w_we;
    // mask written under the tag being started, read under the completed tag
    bfs_ram #(.WIDTH(HOSTS), .DEPTH(TAG_COUNT)) u_ram (
        .i_clk, .i_we(w_we), .i_waddr(TW'(w_cur_tag)), .i_wdata(r_mask),
        .i_raddr(r_ctag), .o_rdata(w_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE) && !r_ov;
    assign w_acc  = i_in.valid && i_in.ready;
    assign w_oacc = o_out.valid && o_out.ready;
    assign w_cur_tag  = w_tag[r_idx];
    assign w_cur_size = w_size[r_idx];
    assign w_cfg = (i_cfg_data > 7'(HOSTS)) ? HW'(HOSTS) : HW'(i_cfg_data);
    always_comb begin
        w_cfg_mask = '0;
        for (int i = 0; i < HOSTS; i++) w_cfg_mask[i] = (i < int'(w_cfg));
    end
    assign w_reject = ({1'b0, i_in.hosts_wanted} > 9'(r_hc))
                      || (9'(i_in.job_tag) >= 9'(TAG_COUNT));
    assign w_full   = r_cnt >= QW'(QUEUE_DEPTH);
    assign w_load   = w_acc && i_in.opcode == OP_SUBMIT && !w_reject && !w_full;
    assign w_shift  = (r_state == S_EMIT) && (!r_ov || w_oacc);
    assign w_end_go = (r_state == S_END) && (!r_ov || w_oacc);
    // a new beat enters the output register
    assign w_oset   = (w_acc && i_in.opcode == OP_SUBMIT && (w_reject || w_full))
                      || w_shift || w_end_go;
    assign w_we     = w_shift && (32'(w_cur_tag) < TAG_COUNT);

    assign o_out.valid         = r_ov;
    assign o_out.result_kind   = r_okind;
    assign o_out.result_tag    = r_otag;
    assign o_out.host_mask     = r_omask;
    assign o_out.last_of_batch = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '0;
            r_hc    <= '0;
            r_cnt   <= '0;
            r_rv    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_oset) r_ov <= 1'b1;
            else if (w_oacc) r_ov <= 1'b0;
            if (i_cfg_we) begin
                r_hc   <= w_cfg;
                r_free <= r_free | w_cfg_mask;
            end
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    r_ctag <= TW'(i_in.job_tag);
                    unique case (i_in.opcode)
                        OP_SUBMIT: begin
                            if (w_reject) r_okind <= RK_REJECT;
                            else if (w_full) r_okind <= RK_DROP;
                            else r_cnt <= r_cnt + 1'b1;
                            r_otag  <= i_in.job_tag;
                            r_omask <= '0;
                            r_olast <= 1'b1;
                        end
                        OP_COMPLETE:
                            if (9'(i_in.job_tag) < 9'(TAG_COUNT)) r_state <= S_CRD;
                        OP_DECIDE: begin
                            r_idx <= '0;
                            r_front_fail <= 1'b0;
                            r_avail <= HW'($countones(r_free));
                            r_state <= (r_cnt == '0) ? S_END : S_SCAN;
                        end
                        default: ;
                    endcase
                end
                S_CRD: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (r_rv[r_ctag]) begin
                        r_free <= r_free | w_rdata;
                        r_rv[r_ctag] <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (9'(r_avail) >= {1'b0, w_cur_size}) begin
                        r_need <= HW'(w_cur_size > 8'(HOSTS) ? 8'(HOSTS) : w_cur_size);
                        r_work <= r_free;
                        r_mask <= '0;
                        r_pos  <= '0;
                        r_state <= S_PICK;
                    end else if (r_idx + 1'b1 >= r_cnt) r_state <= S_END;
                    else begin
                        r_idx <= r_idx + 1'b1;
                        r_front_fail <= 1'b1;
                    end
                end
                S_PICK: begin
                    // one host per cycle, lowest first
                    if (r_need == '0 || r_pos == HW'(HOSTS)) r_state <= S_EMIT;
                    else begin
                        if (r_work[r_pos[PW-1:0]]) begin
                            r_mask[r_pos[PW-1:0]] <= 1'b1;
                            r_need <= r_need - 1'b1;
                        end
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_EMIT: if (w_shift) begin
                    r_okind <= RK_EXEC; r_otag <= w_cur_tag;
                    r_omask <= 64'(r_mask); r_olast <= 1'b0;
                    r_free <= r_free & ~r_mask;
                    r_avail <= HW'($countones(r_free & ~r_mask));
                    if (32'(w_cur_tag) < TAG_COUNT) r_rv[TW'(w_cur_tag)] <= 1'b1;
                    r_cnt <= r_cnt - 1'b1;
                    // a backfilled job ends the pass
                    r_state <= (r_front_fail || r_cnt == QW'(1)) ? S_END : S_SCAN;
                end
                S_END: if (w_end_go) begin
                    r_okind <= RK_END; r_otag <= '0;
                    r_omask <= '0; r_olast <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= QW'(QUEUE_DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> r_cnt != '0) else $error("removal from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> r_ov) else $error("result lost");
endmodule

>>> bench/backfill_job_host_scheduler_unit_checker.sv
`timescale 1ns / 1ps

module backfill_job_host_scheduler_unit_checker import bfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [6:0] i_cfg_data,
    bfs_in_if         mon_in,
    bfs_out_if        mon_out,
    output int        o_failures,
    output int        o_outstanding
);
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tag;
        logic [63:0] mask;
        logic        last;
    } t_sched_beat;

    // mirror of the scheduler state
    logic [6:0]  hosts_total;
    logic [63:0] idle_hosts;
    logic [7:0]  wait_tag  [$];
    logic [7:0]  wait_size [$];
    logic        busy_tag  [256];
    logic [63:0] busy_mask [256];

    t_sched_beat due_beats [$];
    int          fail_cnt;

    assign o_failures    = fail_cnt;
    assign o_outstanding = due_beats.size();

    function automatic int ones(input logic [63:0] v);
        int n;
        n = 0;
        for (int b = 0; b < 64; b++) n += v[b];
        return n;
    endfunction

    function automatic logic [63:0] pick_low(input logic [63:0] v, input int n);
        logic [63:0] m;
        int left;
        m = '0;
        left = n;
        for (int b = 0; b < 64; b++) begin
            if (left > 0 && v[b]) begin
                m[b] = 1'b1;
                left--;
            end
        end
        return m;
    endfunction

    task automatic launch(input int idx);
        t_sched_beat b;
        logic [63:0] m;
        m = pick_low(idle_hosts, wait_size[idx]);
        idle_hosts &= ~m;
        busy_tag[wait_tag[idx]]  = 1'b1;
        busy_mask[wait_tag[idx]] = m;
        b = '{kind: RK_EXEC, tag: wait_tag[idx], mask: m, last: 1'b0};
        due_beats.insert(due_beats.size(), b);
        wait_tag.delete(idx);
        wait_size.delete(idx);
    endtask

    task automatic predict(input logic [1:0] op, input logic [7:0] tag, input logic [7:0] want);
        t_sched_beat b;
        int avail;
        bit stop;
        case (op)
            OP_SUBMIT: begin
                if (want > hosts_total) begin
                    b = '{kind: RK_REJECT, tag: tag, mask: '0, last: 1'b1};
                    due_beats.insert(due_beats.size(), b);
                end else if (wait_tag.size() >= QUEUE_DEPTH_DEF) begin
                    b = '{kind: RK_DROP, tag: tag, mask: '0, last: 1'b1};
                    due_beats.insert(due_beats.size(), b);
                end else begin
                    wait_tag.insert(wait_tag.size(), tag);
                    wait_size.insert(wait_size.size(), want);
                end
            end
            OP_COMPLETE: begin
                if (busy_tag[tag]) begin
                    idle_hosts |= busy_mask[tag];
                    busy_tag[tag] = 1'b0;
                end
            end
            OP_DECIDE: begin
                stop = 1'b0;
                while (wait_tag.size() > 0 && !stop) begin
                    avail = ones(idle_hosts);
                    if (avail >= wait_size[0]) begin
                        launch(0);
                    end else begin
                        // front blocked: backfill the first later fit, then stop
                        for (int i = 1; i < wait_tag.size(); i++) begin
                            if (avail >= wait_size[i]) begin
                                launch(i);
                                break;
                            end
                        end
                        stop = 1'b1;
                    end
                end
                b = '{kind: RK_END, tag: '0, mask: '0, last: 1'b1};
                due_beats.insert(due_beats.size(), b);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_sched_beat exp_b, got_b;
        logic [6:0]  v;
        if (!i_rst_n) begin
            hosts_total = '0;
            idle_hosts  = '0;
            wait_tag.delete();
            wait_size.delete();
            for (int t = 0; t < 256; t++) busy_tag[t] = 1'b0;
            due_beats.delete();
            fail_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                v = (i_cfg_data > 7'd64) ? 7'd64 : i_cfg_data;
                hosts_total = v;
                if (v == 7'd64) idle_hosts = '1;
                else idle_hosts |= (64'd1 << v) - 64'd1;
            end
            if (mon_in.valid && mon_in.ready)
                predict(mon_in.opcode, mon_in.job_tag, mon_in.hosts_wanted);
            if (mon_out.valid && mon_out.ready) begin
                got_b = '{kind: mon_out.result_kind, tag: mon_out.result_tag,
                          mask: mon_out.host_mask, last: mon_out.last_of_batch};
                if (due_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got_b);
                    fail_cnt++;
                end else begin
                    exp_b = due_beats[0];
                    due_beats.delete(0);
                    if (got_b.kind !== exp_b.kind || got_b.tag !== exp_b.tag ||
                        got_b.mask !== exp_b.mask || got_b.last !== exp_b.last) begin
                        $display("%0t: beat mismatch, expected kind %0d tag %0d mask %h last %0d",
                                 $time, exp_b.kind, exp_b.tag, exp_b.mask, exp_b.last);
                        $display("%0t:                 actual   kind %0d tag %0d mask %h last %0d",
                                 $time, got_b.kind, got_b.tag, got_b.mask, got_b.last);
                        fail_cnt++;
                    end
                end
            end
        end
    end
endmodule

>>> bench/backfill_job_host_scheduler_unit_test.sv
`timescale 1ns / 1ps

module backfill_job_host_scheduler_unit_test;
    import bfs_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_data;
    int         failures;
    int         outstanding;

    bfs_in_if  in_ch ();
    bfs_out_if out_ch ();

    // calm: no idling on either side (final stretch)
    bit         calm;
    int         hosts_now;     // saturated host_count, to steer request sizes
    logic [7:0] recent_tags [$];

    backfill_job_host_scheduler_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    backfill_job_host_scheduler_unit_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .mon_in        (in_ch),
        .mon_out       (out_ch),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #15ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: stall in short random bursts unless calm
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready = 1'b0;
                stall_left   = $urandom_range(0, 3);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // one beat on the input channel; valid stays up between back-to-back beats
    task automatic send(input logic [1:0] op, input logic [7:0] tag, input logic [7:0] want);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.opcode       = op;
        in_ch.job_tag      = tag;
        in_ch.hosts_wanted = want;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (op == OP_SUBMIT) begin
            recent_tags.insert(recent_tags.size(), tag);
            if (recent_tags.size() > 24) recent_tags.delete(0);
        end
    endtask

    // drain every expected beat, then let trailing completions settle
    task automatic settle();
        in_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    // host_count may only change while the unit is idle
    task automatic set_hosts(input logic [6:0] v);
        settle();
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        hosts_now  = (v > 64) ? 64 : v;
    endtask

    task automatic random_item();
        int r;
        logic [7:0] tag;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            // mostly sizes that can be granted, some oversized for rejects
            if ($urandom_range(0, 99) < 85)
                send(OP_SUBMIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, hosts_now)));
            else
                send(OP_SUBMIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (r < 75) begin
            if (recent_tags.size() > 0 && $urandom_range(0, 4) != 0)
                tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
            else
                tag = 8'($urandom_range(0, 255));
            send(OP_COMPLETE, tag, 8'($urandom_range(0, 255)));
        end else if (r < 95) begin
            send(OP_DECIDE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
            // undefined opcode, must be ignored
            send(2'd3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int plan [6];
        plan = '{64, 1, 0, 37, 127, 0};
        calm               = 1'b0;
        hosts_now          = 0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_SUBMIT;
        in_ch.job_tag      = '0;
        in_ch.hosts_wanted = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // no hosts yet: zero-host job still runs with an empty mask
        send(OP_SUBMIT, 8'd5, 8'd0);
        send(OP_SUBMIT, 8'd6, 8'd1);          // wants more than exist
        send(OP_DECIDE, 8'd0, 8'd0);
        send(OP_COMPLETE, 8'd9, 8'd0);        // tag never ran
        send(2'd3, 8'hff, 8'hff);
        send(OP_DECIDE, 8'd0, 8'd0);          // empty queue, batch end only

        set_hosts(7'd100);                    // saturates to full platform
        send(OP_SUBMIT, 8'd0, 8'd64);
        send(OP_SUBMIT, 8'd255, 8'd255);
        send(OP_SUBMIT, 8'd1, 8'd63);
        send(OP_SUBMIT, 8'd2, 8'd0);
        send(OP_DECIDE, 8'd0, 8'd0);          // tag 0 takes all, tag 2 backfilled
        send(OP_COMPLETE, 8'd0, 8'd0);
        send(OP_DECIDE, 8'd0, 8'd0);
        send(OP_SUBMIT, 8'd1, 8'd1);          // restart of a running tag
        send(OP_DECIDE, 8'd0, 8'd0);
        send(OP_COMPLETE, 8'd1, 8'd0);
        send(OP_COMPLETE, 8'd1, 8'd0);        // second time: no longer running

        // random phases, each under its own host_count; rewrites free busy hosts
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                plan[5] = $urandom_range(0, 127);
                calm    = 1'b1;
            end
            set_hosts(7'(plan[ph]));
            repeat (70) random_item();
            send(OP_DECIDE, 8'd0, 8'd0);
        end

        settle();
        repeat (50) @(negedge i_clk);
        if (failures == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
